### design/ccm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ccm_pkg
// Shared types and constants for the 3x3 color matrix converter.
// ----------------------------------------------------------------------------
package ccm_pkg;

    // Datapath geometry.
    localparam int C_LANES     = 4;
    localparam int C_CHANS     = 3;
    localparam int C_CFG_W     = 64;
    localparam int C_CFG_IDX_W = 3;

    // Configuration register indexes.
    localparam logic [C_CFG_IDX_W-1:0] CFG_COEF_ROW0    = 3'd0;
    localparam logic [C_CFG_IDX_W-1:0] CFG_COEF_ROW1    = 3'd1;
    localparam logic [C_CFG_IDX_W-1:0] CFG_COEF_ROW2    = 3'd2;
    localparam logic [C_CFG_IDX_W-1:0] CFG_PRE_OFFSETS  = 3'd3;
    localparam logic [C_CFG_IDX_W-1:0] CFG_POST_OFFSETS = 3'd4;
    localparam logic [C_CFG_IDX_W-1:0] CFG_FRAC_SHIFT   = 3'd5;
    localparam logic [C_CFG_IDX_W-1:0] CFG_RGB_MODE     = 3'd6;

    // One 16-bit lane word and the four words of one pixel.
    typedef logic [15:0] t_word;
    typedef t_word [C_LANES-1:0] t_word_vec;

    // A 64-bit register holding four 16-bit lanes.
    typedef logic [C_CFG_W-1:0] t_lanes64;

    // Wrapping 32-bit dot product.
    typedef logic signed [31:0] t_acc;

    // Load enables of the two dot-product stages.
    typedef struct packed {
        logic en_mul;
        logic en_sum;
    } t_dot_ctrl;

endpackage : ccm_pkg
`default_nettype wire

### design/ccm_prep.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ccm_prep
// Input stage: widens the pixel bytes to 16-bit words and adds the
// per-lane pre-offsets with 16-bit wrap.
// ----------------------------------------------------------------------------
module ccm_prep (
    input  wire logic              i_clk,
    input  wire logic              i_en,
    input  wire logic [7:0]        i_in_c0,
    input  wire logic [7:0]        i_in_c1,
    input  wire logic [7:0]        i_in_c2,
    input  wire logic [7:0]        i_in_c3,
    input  wire ccm_pkg::t_lanes64 i_pre_offsets,
    input  wire logic              i_rgb_mode,
    output ccm_pkg::t_word_vec     o_word
);
    import ccm_pkg::*;

    t_word_vec n_word;
    t_word_vec r_word;

    // Before its pre-offset, the fourth word is the byte itself in RGB mode, otherwise all ones.
    always_comb begin
        n_word[0] = {8'h00, i_in_c0} + i_pre_offsets[15:0];
        n_word[1] = {8'h00, i_in_c1} + i_pre_offsets[31:16];
        n_word[2] = {8'h00, i_in_c2} + i_pre_offsets[47:32];
        n_word[3] = (i_rgb_mode ? {8'h00, i_in_c3} : 16'hFFFF) + i_pre_offsets[63:48];
    end

    // Word register; holds while the stage is stalled.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_word <= n_word;
        end
    end

    assign o_word = r_word;

endmodule : ccm_prep
`default_nettype wire

### design/ccm_dot.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ccm_dot
// One output channel's dot product: four registered signed 16x16
// products, then a registered wrapping 32-bit sum.
// ----------------------------------------------------------------------------
module ccm_dot (
    input  wire logic               i_clk,
    input  wire ccm_pkg::t_dot_ctrl i_ctrl,
    input  wire ccm_pkg::t_word_vec i_word,
    input  wire ccm_pkg::t_lanes64  i_coef,
    output ccm_pkg::t_acc           o_acc
);
    import ccm_pkg::*;

    t_acc r_prod [C_LANES];
    t_acc n_acc;
    t_acc r_acc;

    // Product stage: each product fits 32 bits exactly.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.en_mul) begin
            for (int j = 0; j < C_LANES; j++) begin
                r_prod[j] <= $signed(i_word[j]) * $signed(i_coef[16*j +: 16]);
            end
        end
    end

    // Sum stage: the sum wraps at 32 bits.
    always_comb begin
        n_acc = r_prod[0] + r_prod[1] + r_prod[2] + r_prod[3];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.en_sum) begin
            r_acc <= n_acc;
        end
    end

    assign o_acc = r_acc;

endmodule : ccm_dot
`default_nettype wire

### design/ccm_post.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ccm_post
// Output stage of one channel: arithmetic shift, signed 16-bit saturation,
// post-offset with 16-bit wrap and saturation to an unsigned byte.
// ----------------------------------------------------------------------------
module ccm_post (
    input  wire logic           i_clk,
    input  wire logic           i_en,
    input  wire ccm_pkg::t_acc  i_acc,
    input  wire logic [4:0]     i_frac_shift,
    input  wire ccm_pkg::t_word i_post_offset,
    output logic [7:0]          o_byte
);
    import ccm_pkg::*;

    t_acc        n_shift;
    t_word       n_sat16;
    t_word       n_post;
    logic [7:0]  n_byte;
    logic [7:0]  r_byte;

    always_comb begin
        // Drop the fraction bits, keeping the sign.
        n_shift = i_acc >>> i_frac_shift;

        // Clamp to the signed 16-bit range.
        if (n_shift > 32'sd32767) begin
            n_sat16 = 16'h7FFF;
        end else if (n_shift < -32'sd32768) begin
            n_sat16 = 16'h8000;
        end else begin
            n_sat16 = n_shift[15:0];
        end

        // Post-offset wraps at 16 bits and is read as signed.
        n_post = n_sat16 + i_post_offset;

        // Clamp to 0..255.
        if (n_post[15]) begin
            n_byte = 8'h00;
        end else if (|n_post[14:8]) begin
            n_byte = 8'hFF;
        end else begin
            n_byte = n_post[7:0];
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_byte <= n_byte;
        end
    end

    assign o_byte = r_byte;

endmodule : ccm_post
`default_nettype wire

### design/color_matrix_3x3_convert_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// color_matrix_3x3_convert_unit
// Per-pixel fixed-point 3x3 color matrix converter with a constant column,
// pre- and post-offsets and byte saturation.
// ----------------------------------------------------------------------------
// The unit returns each pixel converted through a four-stage pipeline:
// pre-offset words, twelve parallel 16x16 products, the per-channel 32-bit
// sums, and the shift / saturate / post-offset stage that feeds the output
// register. Each stage moves on when the stage after it is empty or moving,
// so bubbles are squeezed out and new pixels keep entering while a finished
// pixel waits at the output. Throughput is one pixel per cycle while the
// output is not stalled.
// Configuration registers are written through a plain write port and must
// only be changed while the pipeline is empty.
// ----------------------------------------------------------------------------
module color_matrix_3x3_convert_unit (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // Configuration write port.
    input  wire logic                                i_cfg_we,
    input  wire logic [ccm_pkg::C_CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [ccm_pkg::C_CFG_W-1:0]         i_cfg_data,
    // Pixel input channel.
    input  wire logic                                i_valid,
    output logic                                     o_ready,
    input  wire logic [7:0]                          i_in_c0,
    input  wire logic [7:0]                          i_in_c1,
    input  wire logic [7:0]                          i_in_c2,
    input  wire logic [7:0]                          i_in_c3,
    // Pixel output channel.
    output logic                                     o_valid,
    input  wire logic                                i_ready,
    output logic [7:0]                               o_out_c0,
    output logic [7:0]                               o_out_c1,
    output logic [7:0]                               o_out_c2,
    output logic [7:0]                               o_out_c3
);
    import ccm_pkg::*;

    // Configuration registers.
    t_lanes64    r_coef_row [C_CHANS];
    t_lanes64    r_pre_offsets;
    t_lanes64    r_post_offsets;
    logic [4:0]  r_frac_shift;
    logic        r_rgb_mode;

    // Stage valid flags and stage readiness.
    logic        r_v1, r_v2, r_v3, r_v4;
    logic        rdy1, rdy2, rdy3, rdy4;
    t_dot_ctrl   dot_ctrl;

    t_word_vec   word;
    t_acc        acc [C_CHANS];
    logic [7:0]  chan [C_CHANS];

    // Configuration writes; unknown indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < C_CHANS; k++) begin
                r_coef_row[k] <= '0;
            end
            r_pre_offsets  <= '0;
            r_post_offsets <= '0;
            r_frac_shift   <= '0;
            r_rgb_mode     <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_COEF_ROW0:    r_coef_row[0]  <= i_cfg_data;
                CFG_COEF_ROW1:    r_coef_row[1]  <= i_cfg_data;
                CFG_COEF_ROW2:    r_coef_row[2]  <= i_cfg_data;
                CFG_PRE_OFFSETS:  r_pre_offsets  <= i_cfg_data;
                CFG_POST_OFFSETS: r_post_offsets <= i_cfg_data;
                CFG_FRAC_SHIFT:   r_frac_shift   <= i_cfg_data[4:0];
                CFG_RGB_MODE:     r_rgb_mode     <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // A stage can load when it is empty or its content moves on.
    assign rdy4 = !r_v4 || i_ready;
    assign rdy3 = !r_v3 || rdy4;
    assign rdy2 = !r_v2 || rdy3;
    assign rdy1 = !r_v1 || rdy2;

    assign dot_ctrl.en_mul = rdy2 && r_v1;
    assign dot_ctrl.en_sum = rdy3 && r_v2;

    // Valid flags of the four stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (rdy1) begin
                r_v1 <= i_valid;
            end
            if (rdy2) begin
                r_v2 <= r_v1;
            end
            if (rdy3) begin
                r_v3 <= r_v2;
            end
            if (rdy4) begin
                r_v4 <= r_v3;
            end
        end
    end

    // Pre-offset stage.
    ccm_prep u_prep (
        .i_clk         (i_clk),
        .i_en          (rdy1 && i_valid),
        .i_in_c0       (i_in_c0),
        .i_in_c1       (i_in_c1),
        .i_in_c2       (i_in_c2),
        .i_in_c3       (i_in_c3),
        .i_pre_offsets (r_pre_offsets),
        .i_rgb_mode    (r_rgb_mode),
        .o_word        (word)
    );

    // One dot product and one output stage per channel.
    for (genvar k = 0; k < C_CHANS; k++) begin : g_chan
        ccm_dot u_dot (
            .i_clk  (i_clk),
            .i_ctrl (dot_ctrl),
            .i_word (word),
            .i_coef (r_coef_row[k]),
            .o_acc  (acc[k])
        );

        ccm_post u_post (
            .i_clk         (i_clk),
            .i_en          (rdy4 && r_v3),
            .i_acc         (acc[k]),
            .i_frac_shift  (r_frac_shift),
            .i_post_offset (r_post_offsets[16*k +: 16]),
            .o_byte        (chan[k])
        );
    end

    // Output channel.
    assign o_ready  = rdy1;
    assign o_valid  = r_v4;
    assign o_out_c0 = chan[0];
    assign o_out_c1 = chan[1];
    assign o_out_c2 = chan[2];
    assign o_out_c3 = r_rgb_mode ? 8'hFF : chan[2];

    // An empty first stage always takes a transfer.
    a_empty_ready : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_v1 |-> o_ready)
        else $error("input stalled with an empty first stage");

    // A full pipeline with a stalled output refuses input.
    a_full_stall : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && r_v2 && r_v3 && r_v4 && !i_ready) |-> !o_ready)
        else $error("input taken while the pipeline is full and stalled");

    // A stalled result stays valid, with channels 0 and 2 unchanged, on the next cycle.
    a_out_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(chan[0]) && $stable(chan[2])))
        else $error("stalled result lost or changed");

    // Outside RGB mode the fourth channel mirrors channel 2.
    a_c3_copy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !r_rgb_mode) |-> (o_out_c3 == o_out_c2))
        else $error("fourth channel differs from channel 2");

endmodule : color_matrix_3x3_convert_unit
`default_nettype wire

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the 3x3 color matrix converter.
// ----------------------------------------------------------------------------
// A short stimulus table covers the corner values of the pixel bytes and the
// registers. It also covers the constant column, both offsets, wrap of the
// 32-bit dot product, oversized register writes and a write to the unused
// index. Random phases follow, each with its own register setting and its
// own mix of sender gaps and receiver stalls. One phase includes a long
// receiver hold-off, which backs the pipeline up into its input. Every
// output transfer is compared field by field against a known result or a
// local model of the conversion.
// ----------------------------------------------------------------------------
module tb;
    import ccm_pkg::*;

    localparam int CLK_HALF      = 10;
    localparam int RESET_CYCLES  = 12;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 80;
    localparam int PHASES        = 8;
    localparam int PHASE_PIXELS  = 175;
    localparam int LIMIT_CYCLES  = 200000;
    localparam int IDLE_HEAVY    = 76;
    localparam int IDLE_LIGHT    = 19;

    // Index with no register behind it; writes to it must be ignored.
    localparam logic [C_CFG_IDX_W-1:0] CFG_IDX_UNUSED = 3'd7;

    // One pixel, byte 3 in the top bits.
    typedef struct packed {
        logic [7:0] c3;
        logic [7:0] c2;
        logic [7:0] c1;
        logic [7:0] c0;
    } t_pixel;

    // Rows of the directed stimulus table.
    typedef enum logic [1:0] {
        ROW_CFG,
        ROW_PIX,
        ROW_PIX_KNOWN
    } t_row_kind;

    typedef struct packed {
        t_row_kind              kind;
        logic [C_CFG_IDX_W-1:0] idx;
        t_lanes64               data;
        t_pixel                 px;
        t_pixel                 known;
    } t_dir_row;

    // Flavors of random register settings.
    typedef enum int {
        SET_TYPICAL,
        SET_WILD,
        SET_CORNER
    } t_setting_style;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [C_CFG_IDX_W-1:0] i_cfg_idx;
    logic [C_CFG_W-1:0]     i_cfg_data;
    logic                   i_valid;
    logic                   o_ready;
    logic [7:0]             i_in_c0;
    logic [7:0]             i_in_c1;
    logic [7:0]             i_in_c2;
    logic [7:0]             i_in_c3;
    logic                   o_valid;
    logic                   i_ready;
    logic [7:0]             o_out_c0;
    logic [7:0]             o_out_c1;
    logic [7:0]             o_out_c2;
    logic [7:0]             o_out_c3;

    // Shadow copy of the converter's registers.
    t_lanes64   mat_coef [3];
    t_lanes64   mat_pre;
    t_lanes64   mat_post;
    logic [4:0] mat_shift;
    logic       mat_rgb;

    t_pixel   pending_pixels [$];
    t_dir_row dir_tbl [$];
    int       mismatch_count = 0;
    int       cycle_count    = 0;
    int       tx_idle_pct    = 0;
    int       rx_stall_pct   = 0;
    bit       hold_req       = 1'b0;

    color_matrix_3x3_convert_unit DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_in_c0    (i_in_c0),
        .i_in_c1    (i_in_c1),
        .i_in_c2    (i_in_c2),
        .i_in_c3    (i_in_c3),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_out_c0   (o_out_c0),
        .o_out_c1   (o_out_c1),
        .o_out_c2   (o_out_c2),
        .o_out_c3   (o_out_c3)
    );

    // Free-running clock.
    initial i_clk = 1'b0;
    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // Converts one pixel with the shadow registers.
    function automatic t_pixel convert_pixel(input t_pixel px);
        t_word              w [4];
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic signed [31:0] dot;
        logic signed [31:0] scaled;
        logic signed [15:0] clip16;
        logic signed [15:0] biased;
        logic [7:0]         chan [3];
        int                 j;
        int                 k;
        w[0] = {8'h00, px.c0} + mat_pre[15:0];
        w[1] = {8'h00, px.c1} + mat_pre[31:16];
        w[2] = {8'h00, px.c2} + mat_pre[47:32];
        // Without RGB mode the fourth word is -1 plus its pre-offset, making column 3 a constant.
        w[3] = (mat_rgb ? {8'h00, px.c3} : 16'hFFFF) + mat_pre[63:48];
        for (k = 0; k < 3; k++) begin
            dot = '0;
            for (j = 0; j < 4; j++) begin
                a   = $signed(w[j]);
                b   = $signed(mat_coef[k][16*j +: 16]);
                dot = dot + a * b;
            end
            scaled = dot >>> mat_shift;
            if (scaled > 32'sd32767) begin
                clip16 = 16'sh7FFF;
            end else if (scaled < -32'sd32768) begin
                clip16 = 16'sh8000;
            end else begin
                clip16 = scaled[15:0];
            end
            biased = clip16 + mat_post[16*k +: 16];
            if (biased[15]) begin
                chan[k] = 8'h00;
            end else if (biased > 16'sd255) begin
                chan[k] = 8'hFF;
            end else begin
                chan[k] = biased[7:0];
            end
        end
        return {mat_rgb ? 8'hFF : chan[2], chan[2], chan[1], chan[0]};
    endfunction

    function automatic t_dir_row cfg_row(input logic [C_CFG_IDX_W-1:0] idx,
                                         input t_lanes64 data);
        t_dir_row r;
        r      = '0;
        r.kind = ROW_CFG;
        r.idx  = idx;
        r.data = data;
        return r;
    endfunction

    function automatic t_dir_row pix_row(input t_pixel px);
        t_dir_row r;
        r      = '0;
        r.kind = ROW_PIX;
        r.px   = px;
        return r;
    endfunction

    function automatic t_dir_row known_row(input t_pixel px, input t_pixel res);
        t_dir_row r;
        r       = '0;
        r.kind  = ROW_PIX_KNOWN;
        r.px    = px;
        r.known = res;
        return r;
    endfunction

    // One 16-bit lane of a random setting; span bounds typical values.
    function automatic t_word random_lane(input t_setting_style style, input int span);
        int v;
        case (style)
            SET_TYPICAL: v = int'($urandom_range(2 * span, 0)) - span;
            SET_WILD:    v = $urandom;
            default: begin
                case ($urandom_range(4, 0))
                    0:       v = 32'h8000;
                    1:       v = 32'h7FFF;
                    2:       v = 32'h0000;
                    3:       v = 32'hFFFF;
                    default: v = 32'h0001;
                endcase
            end
        endcase
        return v[15:0];
    endfunction

    // Register write; the write enable stays high for a following write.
    task automatic write_reg(input logic [C_CFG_IDX_W-1:0] idx, input t_lanes64 data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            CFG_COEF_ROW0:    mat_coef[0] = data;
            CFG_COEF_ROW1:    mat_coef[1] = data;
            CFG_COEF_ROW2:    mat_coef[2] = data;
            CFG_PRE_OFFSETS:  mat_pre     = data;
            CFG_POST_OFFSETS: mat_post    = data;
            CFG_FRAC_SHIFT:   mat_shift   = data[4:0];
            CFG_RGB_MODE:     mat_rgb     = data[0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // Writes every register with a fresh setting of the given flavor.
    task automatic program_random_setting(input t_setting_style style);
        t_lanes64   regs [5];
        logic [4:0] sh;
        int         r;
        int         j;
        case (style)
            SET_TYPICAL: sh = 5'($urandom_range(10, 6));
            SET_WILD:    sh = 5'($urandom_range(31, 0));
            default:     sh = $urandom_range(1, 0) ? 5'd31 : 5'd0;
        endcase
        for (r = 0; r < 3; r++) begin
            for (j = 0; j < 4; j++) begin
                regs[r][16*j +: 16] = random_lane(style, 2 << sh);
            end
        end
        for (j = 0; j < 4; j++) begin
            regs[3][16*j +: 16] = random_lane(style, 32);
            regs[4][16*j +: 16] = random_lane(style, 64);
        end
        write_reg(CFG_COEF_ROW0, regs[0]);
        write_reg(CFG_COEF_ROW1, regs[1]);
        write_reg(CFG_COEF_ROW2, regs[2]);
        write_reg(CFG_PRE_OFFSETS, regs[3]);
        write_reg(CFG_POST_OFFSETS, regs[4]);
        // Upper bits of the narrow registers carry random junk.
        write_reg(CFG_FRAC_SHIFT, {$urandom, 27'($urandom), sh});
        write_reg(CFG_RGB_MODE, {$urandom, $urandom});
        if ($urandom_range(1, 0)) begin
            write_reg(CFG_IDX_UNUSED, {$urandom, $urandom});
        end
    endtask

    // Offers one pixel and records its expected conversion on transfer.
    task automatic send_pixel(input t_pixel px, input bit is_known, input t_pixel known);
        i_cfg_we <= 1'b0;
        while ($urandom_range(99, 0) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_in_c0 <= px.c0;
        i_in_c1 <= px.c1;
        i_in_c2 <= px.c2;
        i_in_c3 <= px.c3;
        @(posedge i_clk);
        while (o_ready !== 1'b1) @(posedge i_clk);
        pending_pixels.push_back(is_known ? known : convert_pixel(px));
    endtask

    // Stops the pixel stream and lets the pipeline run empty.
    task automatic quiesce();
        i_valid  <= 1'b0;
        i_cfg_we <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic compare_field(input string name, input logic [7:0] want,
                                 input logic [7:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    // Receiver: random stalls, plus one long hold-off on request.
    initial begin
        i_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            i_ready <= ($urandom_range(99, 0) >= rx_stall_pct);
        end
    end

    // Output checker: each output transfer against the oldest expectation.
    always @(posedge i_clk) begin
        t_pixel got;
        t_pixel want;
        if (i_rst_n === 1'b1 && o_valid === 1'b1 && i_ready === 1'b1) begin
            got = {o_out_c3, o_out_c2, o_out_c1, o_out_c0};
            if (pending_pixels.size() == 0) begin
                $error("output transfer %h with no pixel outstanding", got);
                mismatch_count++;
            end else begin
                want = pending_pixels.pop_front();
                compare_field("out_c0", want.c0, got.c0);
                compare_field("out_c1", want.c1, got.c1);
                compare_field("out_c2", want.c2, got.c2);
                compare_field("out_c3", want.c3, got.c3);
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Main sequence: reset, directed table, random phases, verdict.
    initial begin
        int     row;
        int     phase;
        int     n;
        bit     bus_quiet;
        t_pixel px;
        i_rst_n    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = '0;
        i_cfg_data = '0;
        i_valid    = 1'b0;
        i_in_c0    = '0;
        i_in_c1    = '0;
        i_in_c2    = '0;
        i_in_c3    = '0;
        mat_coef[0] = '0;
        mat_coef[1] = '0;
        mat_coef[2] = '0;
        mat_pre     = '0;
        mat_post    = '0;
        mat_shift   = '0;
        mat_rgb     = 1'b0;

        // Pixels are written c3_c2_c1_c0.
        // Reset values: all coefficients zero, so everything converts to 0.
        dir_tbl.push_back(known_row(32'h00_00_00_00, 32'h00_00_00_00));
        dir_tbl.push_back(known_row(32'hFF_FF_FF_FF, 32'h00_00_00_00));
        // Identity matrix in RGB mode: bytes pass through, byte 3 is 255.
        dir_tbl.push_back(cfg_row(CFG_COEF_ROW0, 64'h0000_0000_0000_0001));
        dir_tbl.push_back(cfg_row(CFG_COEF_ROW1, 64'h0000_0000_0001_0000));
        dir_tbl.push_back(cfg_row(CFG_COEF_ROW2, 64'h0000_0001_0000_0000));
        dir_tbl.push_back(cfg_row(CFG_RGB_MODE, 64'h1));
        dir_tbl.push_back(known_row(32'h00_00_00_00, 32'hFF_00_00_00));
        dir_tbl.push_back(known_row(32'hFF_FF_FF_FF, 32'hFF_FF_FF_FF));
        dir_tbl.push_back(known_row(32'h55_AA_55_AA, 32'hFF_AA_55_AA));
        dir_tbl.push_back(known_row(32'hAA_55_AA_55, 32'hFF_55_AA_55));
        // Identity without RGB mode: byte 3 follows channel 2.
        dir_tbl.push_back(cfg_row(CFG_RGB_MODE, 64'h0));
        dir_tbl.push_back(known_row(32'h12_34_56_78, 32'h34_34_56_78));
        // Oversized values keep only their low bits; the unused index is ignored.
        dir_tbl.push_back(cfg_row(CFG_FRAC_SHIFT, 64'hFFFF_FFFF_FFFF_FFE4));
        dir_tbl.push_back(cfg_row(CFG_RGB_MODE, 64'hFFFF_FFFF_FFFF_FFFE));
        dir_tbl.push_back(cfg_row(CFG_IDX_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF));
        dir_tbl.push_back(known_row(32'h00_F0_80_10, 32'h0F_0F_08_01));
        // Constant column, a negative gain and a large positive gain.
        dir_tbl.push_back(cfg_row(CFG_COEF_ROW0, 64'hFFF6_0000_0000_0010));
        dir_tbl.push_back(cfg_row(CFG_COEF_ROW1, 64'h0000_0000_FFFF_0000));
        dir_tbl.push_back(cfg_row(CFG_COEF_ROW2, 64'h7FFF_7FFF_7FFF_7FFF));
        dir_tbl.push_back(pix_row(32'h00_00_00_00));
        dir_tbl.push_back(pix_row(32'hFF_FF_FF_FF));
        dir_tbl.push_back(pix_row(32'h3C_C3_81_7E));
        // Pre- and post-offsets together, at their extremes.
        dir_tbl.push_back(cfg_row(CFG_PRE_OFFSETS, 64'h8000_7FFF_FFFF_0001));
        dir_tbl.push_back(cfg_row(CFG_POST_OFFSETS, 64'h0000_FF80_0080_FFFF));
        dir_tbl.push_back(cfg_row(CFG_FRAC_SHIFT, 64'h0));
        dir_tbl.push_back(cfg_row(CFG_RGB_MODE, 64'h1));
        dir_tbl.push_back(pix_row(32'h00_00_00_00));
        dir_tbl.push_back(pix_row(32'hFF_FF_FF_FF));
        // Most negative words times most negative coefficients: the sum wraps.
        dir_tbl.push_back(cfg_row(CFG_COEF_ROW0, 64'h8000_8000_8000_8000));
        dir_tbl.push_back(cfg_row(CFG_COEF_ROW1, 64'h8000_8000_8000_8000));
        dir_tbl.push_back(cfg_row(CFG_COEF_ROW2, 64'h8000_8000_8000_8000));
        dir_tbl.push_back(cfg_row(CFG_PRE_OFFSETS, 64'h8000_8000_8000_8000));
        dir_tbl.push_back(cfg_row(CFG_POST_OFFSETS, 64'h0));
        dir_tbl.push_back(known_row(32'h00_00_00_00, 32'hFF_00_00_00));
        dir_tbl.push_back(pix_row(32'h01_00_00_00));
        // Widest shift, with a post-offset lifting the result.
        dir_tbl.push_back(cfg_row(CFG_FRAC_SHIFT, 64'h1F));
        dir_tbl.push_back(cfg_row(CFG_POST_OFFSETS, 64'hFFFF_0005_0005_0005));
        dir_tbl.push_back(pix_row(32'h00_00_00_00));
        dir_tbl.push_back(pix_row(32'hFF_7F_80_01));

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table. Registers change only with the pipeline empty.
        bus_quiet = 1'b1;
        for (row = 0; row < dir_tbl.size(); row++) begin
            if (dir_tbl[row].kind == ROW_CFG) begin
                if (!bus_quiet) begin
                    quiesce();
                end
                write_reg(dir_tbl[row].idx, dir_tbl[row].data);
                bus_quiet = 1'b1;
            end else begin
                send_pixel(dir_tbl[row].px, dir_tbl[row].kind == ROW_PIX_KNOWN,
                           dir_tbl[row].known);
                bus_quiet = 1'b0;
            end
        end

        // Random phases, each with a new setting and its own idling mix.
        for (phase = 0; phase < PHASES; phase++) begin
            quiesce();
            program_random_setting(t_setting_style'(phase % 3));
            case (phase % 4)
                0: begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 0;
                end
                1: begin
                    tx_idle_pct  = IDLE_HEAVY;
                    rx_stall_pct = 0;
                end
                2: begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = IDLE_HEAVY;
                end
                default: begin
                    tx_idle_pct  = IDLE_LIGHT;
                    rx_stall_pct = IDLE_LIGHT;
                end
            endcase
            for (n = 0; n < PHASE_PIXELS; n++) begin
                // Long receiver hold-off while pixels keep coming back to back.
                if (phase == 0 && n == 40) begin
                    hold_req = 1'b1;
                end
                px = $urandom;
                send_pixel(px, 1'b0, '0);
            end
        end

        quiesce();
        if (mismatch_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
